FILE: rtl/core/tpp_pkg.sv
// ----------------------------------------------------------------------------
// tpp_pkg
// Shared types and constants of the timed path playback block.
// ----------------------------------------------------------------------------
package tpp_pkg;

   localparam int COORD_W = 13;
   localparam int TIME_W  = 32;
   localparam int OUT_W   = 21;
   localparam int OUT_MAX = 1048575;
   localparam int OUT_MIN = -1048576;

   typedef enum logic [1:0] {
      CMD_START  = 2'd0,
      CMD_APPEND = 2'd1,
      CMD_STOP   = 2'd2,
      CMD_QUERY  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_POS   = 2'd0,
      ST_NOPOS = 2'd1,
      ST_DROP  = 2'd2,
      ST_ACK   = 2'd3
   } status_type;

   // read address source of the point store
   typedef enum logic [1:0] {
      RD_LAST = 2'd0,
      RD_SCAN = 2'd1,
      RD_HIT  = 2'd2,
      RD_NEXT = 2'd3
   } rd_sel_type;

   // kind of result loaded into the response register
   typedef enum logic [1:0] {
      KIND_CMD   = 2'd0,
      KIND_NOPOS = 2'd1,
      KIND_POS   = 2'd2
   } kind_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic [TIME_W-1:0]         t;
   } point_type;

   typedef struct packed {
      logic       latch;
      logic       exec;
      rd_sel_type rd_sel;
      logic       len_load;
      logic       scan_init;
      logic       mod_start;
      logic       mod_load;
      logic       scan_issue;
      logic       cap_p0;
      logic       cap_p1;
      logic       mult;
      logic       div_start;
      logic       out_load;
      kind_type   kind;
   } ctl_type;

   typedef struct packed {
      logic is_query;
      logic query_ok;
      logic len_zero;
      logic need_mod;
      logic div_done;
      logic scan_last;
      logic hit;
      logic out_free;
   } stat_type;

endpackage

FILE: rtl/core/timed_path_playback.sv
// ----------------------------------------------------------------------------
// timed_path_playback
// Records a timed path of points and plays it back by linear interpolation.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one transaction per command; tuser carries the command
//   (start, append, stop, query), tdata the point and the current time.
//   rsp channel: exactly one transaction per command, in order; tdata carries
//   the interpolated x and y with FRAC_BITS fraction bits, tuser the status.
//   Commands run one at a time. A query scans the table with one read per
//   stored point over the single memory read port, then runs a 45+FRAC_BITS
//   step bit-serial divide for the interpolation; when the time since
//   playback passes the path length, a modulo divide of the time comes
//   first. A new command is accepted while the previous response waits.
//   Reset clears the point count, the recording flag and both start times;
//   the point table itself is not cleared. If the receiver stalls, the block
//   holds its finished result and waits before loading the next one.
// ----------------------------------------------------------------------------
module timed_path_playback
   import tpp_pkg::*;
#(
   parameter int MAX_POINTS = 1024,
   parameter int FRAC_BITS  = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // pos_x[12:0], pos_y[25:13], now[57:26], zero fill
   input  logic [1:0]  req_tuser,   // cmd[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // out_x[20:0], out_y[41:21], zero fill
   output logic [1:0]  rsp_tuser    // status[1:0]
);

   ctl_type          ctl;
   stat_type         stat;
   logic [OUT_W-1:0] rsp_x, rsp_y;
   status_type       rsp_status;

   tpp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .ctl        (ctl)
   );

   tpp_datapath #(
      .MAX_POINTS (MAX_POINTS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .stat       (stat),
      .req_cmd    (req_tuser),
      .req_x      (req_tdata[12:0]),
      .req_y      (req_tdata[25:13]),
      .req_now    (req_tdata[57:26]),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_x      (rsp_x),
      .rsp_y      (rsp_y),
      .rsp_status (rsp_status)
   );

   assign rsp_tdata = {6'b0, rsp_y, rsp_x};
   assign rsp_tuser = rsp_status;

endmodule

FILE: rtl/core/tpp_point_store.sv
// ----------------------------------------------------------------------------
// tpp_point_store
// Point table memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tpp_point_store
   import tpp_pkg::*;
#(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic            clock,
   input  logic            wr_en,
   input  logic [AW-1:0]   wr_addr,
   input  point_type       wr_data,
   input  logic [AW-1:0]   rd_addr,
   output point_type       rd_data
);

   point_type mem [DEPTH];
   point_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/tpp_divider.sv
// ----------------------------------------------------------------------------
// tpp_divider
// Restoring unsigned divider, one quotient bit per cycle, 32-bit divisor.
// ----------------------------------------------------------------------------
module tpp_divider #(
   parameter int NW = 53
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] dividend,
   input  logic [31:0]   divisor,
   output logic [NW-1:0] quotient,
   output logic [31:0]   remainder,
   output logic          done
);

   localparam int CNW = $clog2(NW + 1);

   logic [NW-1:0]  qd_ff, qd_in;
   logic [31:0]    rem_ff, rem_in;
   logic [31:0]    div_ff;
   logic [CNW-1:0] cnt_ff, cnt_in;
   logic           busy_ff, busy_in;
   logic           done_ff, done_in;
   logic [32:0]    trial;
   logic [33:0]    diff;
   logic           ge;

   // one restoring step
   always_comb begin
      trial = {rem_ff, qd_ff[NW-1]};
      diff  = {1'b0, trial} - {2'b00, div_ff};
      ge    = ~diff[33];
   end

   always_comb begin
      qd_in   = qd_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         qd_in   = dividend;
         rem_in  = '0;
         cnt_in  = CNW'(NW);
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         qd_in  = {qd_ff[NW-2:0], ge};
         rem_in = ge ? diff[31:0] : trial[31:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      qd_ff  <= qd_in;
      rem_ff <= rem_in;
      if (start) begin
         div_ff <= divisor;
      end
   end

   assign quotient  = qd_ff;
   assign remainder = rem_ff;
   assign done      = done_ff;

endmodule

FILE: rtl/core/tpp_datapath.sv
// ----------------------------------------------------------------------------
// tpp_datapath
// Recording state, point table, segment scan, interpolation and response.
// ----------------------------------------------------------------------------
module tpp_datapath
   import tpp_pkg::*;
#(
   parameter int MAX_POINTS = 1024,
   parameter int FRAC_BITS  = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  ctl_type                   ctl,
   output stat_type                  stat,
   input  logic [1:0]                req_cmd,
   input  logic signed [COORD_W-1:0] req_x,
   input  logic signed [COORD_W-1:0] req_y,
   input  logic [TIME_W-1:0]         req_now,
   input  logic                      rsp_tready,
   output logic                      rsp_tvalid,
   output logic [OUT_W-1:0]          rsp_x,
   output logic [OUT_W-1:0]          rsp_y,
   output status_type                rsp_status
);

   localparam int AW = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam int NW = 45 + FRAC_BITS;
   localparam int QW = 14 + FRAC_BITS;
   localparam int RW = (16 + FRAC_BITS > 22) ? 16 + FRAC_BITS : 22;
   localparam logic signed [RW-1:0] OUT_HI = RW'(OUT_MAX);
   localparam logic signed [RW-1:0] OUT_LO = RW'(OUT_MIN);

   // latched request
   cmd_type                   cmd_ff;
   logic signed [COORD_W-1:0] x_ff, y_ff;
   logic [TIME_W-1:0]         now_ff;

   // recording state
   logic [CW-1:0]     count_ff;
   logic              recording_ff;
   logic [TIME_W-1:0] record_start_ff;
   logic [TIME_W-1:0] playback_start_ff;
   status_type        cmd_status_ff;

   // query state
   logic [TIME_W-1:0] len_ff, t_ff;
   logic [CW-1:0]     iss_idx_ff, rd_idx_ff;
   logic              rd_vld_ff;
   logic [TIME_W-1:0] prev_t_ff;
   logic              hit_ff;
   logic [AW-1:0]     hit_idx_ff;
   point_type         p0_ff, p1_ff;
   logic [NW-1:0]     num_x_ff, num_y_ff;
   logic [TIME_W-1:0] whole_ff;
   logic              neg_x_ff, neg_y_ff;
   logic              mod_run_ff;

   // response register
   logic                      rsp_valid_ff;
   logic [OUT_W-1:0]          rsp_x_ff, rsp_y_ff;
   status_type                rsp_status_ff;

   // memory ports
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   point_type     wr_data;
   logic [AW-1:0] rd_addr;
   point_type     rd_data;

   // combinational helpers
   logic [TIME_W-1:0]  t_diff;
   logic [CW-1:0]      last_idx;
   logic signed [13:0] dx, dy;
   logic [12:0]        mag_x, mag_y;
   logic [TIME_W-1:0]  part, whole;
   logic [44:0]        prod_x, prod_y;
   logic [NW-1:0]      dvx_dividend;
   logic [31:0]        dvx_divisor;
   logic               dv_start;
   logic [NW-1:0]      qx, qy;
   logic [31:0]        rx, ry;
   logic               dvx_done, dvy_done;

   // offset from the interpolation start point, floor rounded, then saturate
   function automatic logic [OUT_W-1:0] finish_lerp(
      input logic signed [COORD_W-1:0] a,
      input logic                      neg,
      input logic [QW-1:0]             q,
      input logic                      rnz
   );
      logic signed [RW-1:0] base;
      logic signed [RW-1:0] frac;
      logic signed [RW-1:0] r;
      base = RW'(a) <<< FRAC_BITS;
      frac = RW'(q);
      if (neg) begin
         frac = -(frac + RW'(rnz));
      end
      r = base + frac;
      if (r > OUT_HI) begin
         r = OUT_HI;
      end else if (r < OUT_LO) begin
         r = OUT_LO;
      end
      return r[OUT_W-1:0];
   endfunction

   assign t_diff   = now_ff - playback_start_ff;
   assign last_idx = count_ff - 1'b1;

   // write a point on start and on an append that fits
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = '{x: x_ff, y: y_ff, t: '0};
      if (ctl.exec && cmd_ff == CMD_START) begin
         wr_en = 1'b1;
      end else if (ctl.exec && cmd_ff == CMD_APPEND && count_ff < CW'(MAX_POINTS)) begin
         wr_en     = 1'b1;
         wr_addr   = count_ff[AW-1:0];
         wr_data.t = now_ff - record_start_ff;
      end
   end

   // select the read address
   always_comb begin
      unique case (ctl.rd_sel)
         RD_LAST: rd_addr = last_idx[AW-1:0];
         RD_SCAN: rd_addr = iss_idx_ff[AW-1:0];
         RD_HIT:  rd_addr = hit_idx_ff;
         RD_NEXT: rd_addr = hit_idx_ff + 1'b1;
         default: rd_addr = '0;
      endcase
   end

   tpp_point_store #(
      .DEPTH (MAX_POINTS),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // segment deltas for the multiply stage
   always_comb begin
      dx     = {p1_ff.x[12], p1_ff.x} - {p0_ff.x[12], p0_ff.x};
      dy     = {p1_ff.y[12], p1_ff.y} - {p0_ff.y[12], p0_ff.y};
      mag_x  = dx[13] ? 13'(-dx) : dx[12:0];
      mag_y  = dy[13] ? 13'(-dy) : dy[12:0];
      part   = t_ff - p0_ff.t;
      whole  = p1_ff.t - p0_ff.t;
      prod_x = 45'(mag_x) * 45'(part);
      prod_y = 45'(mag_y) * 45'(part);
   end

   // x lane divider also reduces the query time modulo the path length
   assign dv_start     = ctl.mod_start | ctl.div_start;
   assign dvx_dividend = ctl.mod_start ? NW'(t_diff) : num_x_ff;
   assign dvx_divisor  = ctl.mod_start ? rd_data.t : whole_ff;

   tpp_divider #(.NW (NW)) u_div_x (
      .clock     (clock),
      .reset     (reset),
      .start     (dv_start),
      .dividend  (dvx_dividend),
      .divisor   (dvx_divisor),
      .quotient  (qx),
      .remainder (rx),
      .done      (dvx_done)
   );

   tpp_divider #(.NW (NW)) u_div_y (
      .clock     (clock),
      .reset     (reset),
      .start     (ctl.div_start),
      .dividend  (num_y_ff),
      .divisor   (whole_ff),
      .quotient  (qy),
      .remainder (ry),
      .done      (dvy_done)
   );

   // recording state, updated by start, append and stop
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff          <= '0;
         recording_ff      <= 1'b0;
         record_start_ff   <= '0;
         playback_start_ff <= '0;
      end else if (ctl.exec) begin
         unique case (cmd_ff)
            CMD_START: begin
               count_ff        <= CW'(1);
               recording_ff    <= 1'b1;
               record_start_ff <= now_ff;
            end
            CMD_APPEND: begin
               if (count_ff < CW'(MAX_POINTS)) begin
                  count_ff <= count_ff + 1'b1;
               end
            end
            CMD_STOP: begin
               recording_ff      <= 1'b0;
               playback_start_ff <= now_ff;
            end
            default: begin
            end
         endcase
      end
   end

   // scan control bits
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
         hit_ff    <= 1'b0;
      end else if (ctl.scan_init) begin
         rd_vld_ff <= 1'b0;
         hit_ff    <= 1'b0;
      end else begin
         rd_vld_ff <= ctl.scan_issue;
         if (rd_vld_ff && rd_idx_ff != '0 && t_ff >= prev_t_ff && t_ff < rd_data.t) begin
            hit_ff <= 1'b1;
         end
      end
   end

   // mark a modulo run so only the x lane is awaited
   always_ff @(posedge clock) begin
      if (reset) begin
         mod_run_ff <= 1'b0;
      end else if (ctl.mod_start) begin
         mod_run_ff <= 1'b1;
      end else if (ctl.div_start) begin
         mod_run_ff <= 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (ctl.latch) begin
         cmd_ff <= cmd_type'(req_cmd);
         x_ff   <= req_x;
         y_ff   <= req_y;
         now_ff <= req_now;
      end
      if (ctl.exec) begin
         cmd_status_ff <= (cmd_ff == CMD_APPEND && count_ff >= CW'(MAX_POINTS)) ?
                          ST_DROP : ST_ACK;
      end
      if (ctl.len_load) begin
         len_ff <= rd_data.t;
         t_ff   <= t_diff;
      end
      if (ctl.mod_load) begin
         t_ff <= (rx == '0) ? len_ff : rx;
      end
      if (ctl.scan_init) begin
         iss_idx_ff <= '0;
      end else if (ctl.scan_issue) begin
         iss_idx_ff <= iss_idx_ff + 1'b1;
         rd_idx_ff  <= iss_idx_ff;
      end
      // keep the last bracketing segment
      if (rd_vld_ff) begin
         prev_t_ff <= rd_data.t;
         if (rd_idx_ff != '0 && t_ff >= prev_t_ff && t_ff < rd_data.t) begin
            hit_idx_ff <= AW'(rd_idx_ff - 1'b1);
         end
      end
      if (ctl.cap_p0) begin
         p0_ff <= rd_data;
      end
      if (ctl.cap_p1) begin
         p1_ff <= rd_data;
      end
      if (ctl.mult) begin
         num_x_ff <= NW'(prod_x) << FRAC_BITS;
         num_y_ff <= NW'(prod_y) << FRAC_BITS;
         whole_ff <= whole;
         neg_x_ff <= dx[13];
         neg_y_ff <= dy[13];
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.out_load) begin
         unique case (ctl.kind)
            KIND_POS: begin
               rsp_x_ff      <= finish_lerp(p0_ff.x, neg_x_ff, qx[QW-1:0], rx != '0);
               rsp_y_ff      <= finish_lerp(p0_ff.y, neg_y_ff, qy[QW-1:0], ry != '0);
               rsp_status_ff <= ST_POS;
            end
            KIND_CMD: begin
               rsp_x_ff      <= '0;
               rsp_y_ff      <= '0;
               rsp_status_ff <= cmd_status_ff;
            end
            default: begin
               rsp_x_ff      <= '0;
               rsp_y_ff      <= '0;
               rsp_status_ff <= ST_NOPOS;
            end
         endcase
      end
   end

   // status toward the controller
   always_comb begin
      stat.is_query  = (cmd_ff == CMD_QUERY);
      stat.query_ok  = ~recording_ff && count_ff >= CW'(2);
      stat.len_zero  = (rd_data.t == '0);
      stat.need_mod  = (t_diff > rd_data.t);
      stat.div_done  = dvx_done & (dvy_done | mod_run_ff);
      stat.scan_last = (iss_idx_ff == last_idx);
      stat.hit       = hit_ff;
      stat.out_free  = ~rsp_valid_ff | rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_x      = rsp_x_ff;
   assign rsp_y      = rsp_y_ff;
   assign rsp_status = rsp_status_ff;

endmodule

FILE: rtl/core/tpp_ctrl.sv
// ----------------------------------------------------------------------------
// tpp_ctrl
// Sequencer for command execution and the query search and interpolation.
// ----------------------------------------------------------------------------
module tpp_ctrl
   import tpp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  stat_type stat,
   output ctl_type  ctl
);

   typedef enum logic [12:0] {
      S_IDLE    = 13'b0000000000001,
      S_DECODE  = 13'b0000000000010,
      S_LEN     = 13'b0000000000100,
      S_MOD     = 13'b0000000001000,
      S_SCAN    = 13'b0000000010000,
      S_DRAIN   = 13'b0000000100000,
      S_FETCH_A = 13'b0000001000000,
      S_FETCH_B = 13'b0000010000000,
      S_LOAD_B  = 13'b0000100000000,
      S_MULT    = 13'b0001000000000,
      S_DIV_GO  = 13'b0010000000000,
      S_DIV     = 13'b0100000000000,
      S_DONE    = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;
   kind_type  kind_ff, kind_in;

   always_comb begin
      state_in   = state_ff;
      kind_in    = kind_ff;
      ctl        = '0;
      ctl.rd_sel = RD_LAST;
      ctl.kind   = kind_ff;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            ctl.latch  = req_tvalid;
            if (req_tvalid) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            priority if (!stat.is_query) begin
               ctl.exec = 1'b1;
               kind_in  = KIND_CMD;
               state_in = S_DONE;
            end else if (!stat.query_ok) begin
               kind_in  = KIND_NOPOS;
               state_in = S_DONE;
            end else begin
               state_in = S_LEN;
            end
         end
         S_LEN: begin
            ctl.len_load  = 1'b1;
            ctl.scan_init = 1'b1;
            priority if (stat.len_zero) begin
               kind_in  = KIND_NOPOS;
               state_in = S_DONE;
            end else if (stat.need_mod) begin
               ctl.mod_start = 1'b1;
               state_in      = S_MOD;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_MOD: begin
            if (stat.div_done) begin
               ctl.mod_load = 1'b1;
               state_in     = S_SCAN;
            end
         end
         // issue one table read a cycle
         S_SCAN: begin
            ctl.rd_sel     = RD_SCAN;
            ctl.scan_issue = 1'b1;
            if (stat.scan_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_FETCH_A;
         end
         S_FETCH_A: begin
            ctl.rd_sel = RD_HIT;
            if (stat.hit) begin
               state_in = S_FETCH_B;
            end else begin
               kind_in  = KIND_NOPOS;
               state_in = S_DONE;
            end
         end
         S_FETCH_B: begin
            ctl.rd_sel = RD_NEXT;
            ctl.cap_p0 = 1'b1;
            state_in   = S_LOAD_B;
         end
         S_LOAD_B: begin
            ctl.cap_p1 = 1'b1;
            state_in   = S_MULT;
         end
         S_MULT: begin
            ctl.mult = 1'b1;
            state_in = S_DIV_GO;
         end
         S_DIV_GO: begin
            ctl.div_start = 1'b1;
            state_in      = S_DIV;
         end
         S_DIV: begin
            if (stat.div_done) begin
               kind_in  = KIND_POS;
               state_in = S_DONE;
            end
         end
         // hold until the response register frees up
         S_DONE: begin
            ctl.out_load = stat.out_free;
            if (stat.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         kind_ff  <= KIND_CMD;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end

endmodule

FILE: rtl/core/tpp_checker.sv
// ----------------------------------------------------------------------------
// tpp_checker
// Port-level checks of the timed path playback block, bound to the top.
// ----------------------------------------------------------------------------
module tpp_checker
   import tpp_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   // a pending response stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   // no position means the origin
   a_origin: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_POS |-> rsp_tdata[41:0] == '0)
      else $error("nonzero coordinates without a position");

   // one command in flight at a time
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("command accepted while busy");

   // reset empties the response register
   a_reset_rsp: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response offered after reset");

endmodule

bind timed_path_playback tpp_checker u_tpp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

FILE: test/timed_path_playback_test.sv
// ----------------------------------------------------------------------------
// timed_path_playback_test
// Drives recorded paths and playback queries into the block, predicts every
// response with a local path model and compares each response field by field.
// ----------------------------------------------------------------------------
module timed_path_playback_test;
   import tpp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_DEPTH = 1024;
   localparam int LONG_POINTS = 200;
   localparam int FRACTION    = 8;
   localparam int CYCLE_LIMIT = 2000000;

   typedef struct {
      cmd_type            cmd;
      logic signed [12:0] px;
      logic signed [12:0] py;
      logic [31:0]        now;
   } command_type;

   typedef struct {
      logic [20:0] ox;
      logic [20:0] oy;
      status_type  status;
   } response_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [47:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   timed_path_playback DUT (.*);

   always #5 clock = ~clock;

   // path model state
   logic signed [12:0] path_x [TABLE_DEPTH];
   logic signed [12:0] path_y [TABLE_DEPTH];
   logic [31:0]        path_t [TABLE_DEPTH];
   int unsigned        path_count = 0;
   bit                 path_recording = 0;
   logic [31:0]        path_rec_start = 0;
   logic [31:0]        path_play_start = 0;

   command_type  pending_cmds[$];
   response_type expected_rsps[$];
   int  errors = 0;
   int  cycles = 0;
   bit  calm = 0;        // no idling on either side
   bit  hold_send = 0;   // sender waits for the responses to drain
   bit  stim_done = 0;
   logic [31:0] clock_now = 0;

   // interpolate one coordinate with floor division and saturation
   function automatic logic [20:0] lerp_coord(logic signed [12:0] a, logic signed [12:0] b,
                                              logic [31:0] part, logic [31:0] whole);
      longint d, r;
      longint unsigned mag, num, q;
      d   = longint'(b) - longint'(a);
      mag = (d < 0) ? -d : d;
      num = (mag * part) << FRACTION;
      q   = num / whole;
      if (d < 0 && (num % whole) != 0) q++;
      r = longint'(a) * (1 << FRACTION) + ((d < 0) ? -longint'(q) : longint'(q));
      if (r > OUT_MAX) r = OUT_MAX;
      if (r < OUT_MIN) r = OUT_MIN;
      return r[20:0];
   endfunction

   // advance the path model by one command and return its response
   function automatic response_type path_step(command_type c);
      response_type rsp;
      logic [31:0] len, t, t0, t1;
      rsp = '{ox: '0, oy: '0, status: ST_ACK};
      case (c.cmd)
         CMD_START: begin
            path_x[0] = c.px; path_y[0] = c.py; path_t[0] = 0;
            path_count = 1; path_recording = 1; path_rec_start = c.now;
         end
         CMD_APPEND: begin
            if (path_count >= TABLE_DEPTH) rsp.status = ST_DROP;
            else begin
               path_x[path_count] = c.px; path_y[path_count] = c.py;
               path_t[path_count] = c.now - path_rec_start;
               path_count++;
            end
         end
         CMD_STOP: begin
            path_recording = 0; path_play_start = c.now;
         end
         default: begin
            rsp.status = ST_NOPOS;
            if (!path_recording && path_count >= 2) begin
               len = path_t[path_count-1];
               if (len != 0) begin
                  t = c.now - path_play_start;
                  if (t > len) begin
                     t = t % len;
                     if (t == 0) t = len;
                  end
                  for (int i = 0; i + 1 < path_count; i++) begin
                     t0 = path_t[i]; t1 = path_t[i+1];
                     if (t >= t0 && t < t1) begin
                        rsp.ox = lerp_coord(path_x[i], path_x[i+1], t - t0, t1 - t0);
                        rsp.oy = lerp_coord(path_y[i], path_y[i+1], t - t0, t1 - t0);
                        rsp.status = ST_POS;
                     end
                  end
               end
            end
         end
      endcase
      return rsp;
   endfunction

   // driver: present the next command, predict on each transaction
   always @(posedge clock) begin
      command_type c;
      if (!reset) begin
         if (req_tvalid && req_tready)
            expected_rsps.insert(expected_rsps.size(), path_step(pending_cmds.pop_front()));
         if ((!req_tvalid || req_tready) && pending_cmds.size() > 0 && !hold_send
             && !(req_tvalid && req_tready && pending_cmds.size() == 0)
             && (calm || $urandom_range(99) >= 6)) begin
            c = pending_cmds[0];
            req_tvalid <= 1;
            req_tuser  <= c.cmd;
            req_tdata  <= {6'b0, c.now, c.py, c.px};
         end else if (req_tvalid && req_tready) begin
            req_tvalid <= 0;
         end
      end
   end

   // monitor: stall at random and compare each response transaction
   always @(posedge clock) begin
      response_type e;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: response with none expected: x=%h y=%h status=%0d",
                        $time, rsp_tdata[20:0], rsp_tdata[41:21], rsp_tuser);
               errors++;
            end else begin
               e = expected_rsps.pop_front();
               if (rsp_tdata[20:0] !== e.ox || rsp_tdata[41:21] !== e.oy
                   || rsp_tuser !== e.status) begin
                  $display("%0t: expected x=%h y=%h status=%0d, got x=%h y=%h status=%0d",
                           $time, e.ox, e.oy, e.status,
                           rsp_tdata[20:0], rsp_tdata[41:21], rsp_tuser);
                  errors++;
               end
            end
         end
         rsp_tready <= calm || $urandom_range(99) >= 6;
      end
   end

   // timeout
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic add_cmd(cmd_type cmd, int x, int y, logic [31:0] now);
      pending_cmds.insert(pending_cmds.size(),
                          '{cmd: cmd, px: 13'(x), py: 13'(y), now: now});
   endtask

   // advance the clock value by a random step, never backwards
   task automatic tick(int unsigned hi);
      clock_now += $urandom_range(hi);
   endtask

   // record a path with random content, then query it
   task automatic random_path(int unsigned points, int unsigned queries);
      int unsigned sel;
      tick(50);
      add_cmd(CMD_START, $urandom, $urandom, clock_now);
      for (int i = 1; i < points; i++) begin
         sel = $urandom_range(9);
         if (sel == 0) add_cmd(CMD_QUERY, $urandom, $urandom, clock_now);
         else if (sel == 1) clock_now += 0;
         else tick(sel == 2 ? 100000 : 40);
         add_cmd(CMD_APPEND, $urandom, $urandom, clock_now);
      end
      tick(20);
      add_cmd(CMD_STOP, $urandom, $urandom, clock_now);
      for (int q = 0; q < queries; q++) begin
         if ($urandom_range(9) == 0) clock_now += $urandom;
         else tick(60);
         add_cmd(CMD_QUERY, $urandom, $urandom, clock_now);
      end
   endtask

   task automatic wait_drained();
      while (pending_cmds.size() > 0 || req_tvalid || expected_rsps.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 0;

      // directed: queries with no path, extremes, zero length and wrap
      add_cmd(CMD_QUERY, 0, 0, 32'd5);
      add_cmd(CMD_STOP, 0, 0, 32'd6);
      add_cmd(CMD_APPEND, -4096, 4095, 32'd7);
      add_cmd(CMD_QUERY, 0, 0, 32'd8);
      add_cmd(CMD_START, -4096, 4095, 32'hFFFF_FFF0);
      add_cmd(CMD_QUERY, 0, 0, 32'hFFFF_FFF1);
      add_cmd(CMD_APPEND, 4095, -4096, 32'h0000_0010);
      add_cmd(CMD_APPEND, 3, -7, 32'h0000_0030);
      add_cmd(CMD_STOP, 0, 0, 32'hFFFF_FFFF);
      add_cmd(CMD_QUERY, -1, -1, 32'hFFFF_FFFF);
      add_cmd(CMD_QUERY, 0, 0, 32'h0000_0007);
      add_cmd(CMD_QUERY, 0, 0, 32'h0000_0040);
      add_cmd(CMD_QUERY, 0, 0, 32'h0000_0080);
      add_cmd(CMD_QUERY, 0, 0, 32'hFFFF_FFFE);
      add_cmd(CMD_START, 5, 5, 32'd100);
      add_cmd(CMD_APPEND, 9, 9, 32'd100);
      add_cmd(CMD_STOP, 0, 0, 32'd200);
      add_cmd(CMD_QUERY, 0, 0, 32'd300);
      add_cmd(CMD_START, 0, 0, 32'd1000);
      add_cmd(CMD_APPEND, 100, 100, 32'd1010);
      add_cmd(CMD_APPEND, -100, 50, 32'd1005);
      add_cmd(CMD_APPEND, 1, 1, 32'd1020);
      add_cmd(CMD_STOP, 0, 0, 32'd2000);
      add_cmd(CMD_QUERY, 0, 0, 32'd2007);
      wait_drained();

      // record and query a long path with both sides calm
      calm = 1;
      clock_now = 32'd5000;
      add_cmd(CMD_START, $urandom, $urandom, clock_now);
      for (int i = 1; i < LONG_POINTS; i++) begin
         tick(3);
         add_cmd(CMD_APPEND, $urandom, $urandom, clock_now);
      end
      add_cmd(CMD_STOP, 0, 0, clock_now);
      for (int q = 0; q < 4; q++) begin
         tick(4000);
         add_cmd(CMD_QUERY, 0, 0, clock_now);
      end
      wait_drained();
      calm = 0;

      // random paths, mostly small
      for (int n = 0; n < 30; n++) begin
         if (n == 20) begin
            wait_drained();
            calm = 1;
         end
         if (n == 28) calm = 0;
         random_path($urandom_range(1, 6), $urandom_range(2, 8));
         if ($urandom_range(7) == 0)
            add_cmd(cmd_type'($urandom_range(3)), $urandom, $urandom, clock_now);
      end

      // hold the sender until every response is back
      hold_send = 1;
      wait (pending_cmds.size() == 0 || 1);
      while (expected_rsps.size() > 0 || req_tvalid) @(posedge clock);
      hold_send = 0;
      random_path(4, 5);
      wait_drained();
      repeat (20) @(posedge clock);
      if (errors == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end
endmodule

FILE: timed_path_playback.f
rtl/core/tpp_pkg.sv
rtl/core/tpp_point_store.sv
rtl/core/tpp_divider.sv
rtl/core/tpp_datapath.sv
rtl/core/tpp_ctrl.sv
rtl/core/timed_path_playback.sv
rtl/core/tpp_checker.sv
test/timed_path_playback_test.sv
